FILE: sv/sbpa_pkg.sv
// Shared types and codes of the sharded buffer pool allocator.
`default_nettype none
package sbpa_pkg;

    // input operations
    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_BUILD = 2'd2;

    // result status
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_EMPTY   = 3'd1;
    localparam logic [2:0] ST_INVALID = 3'd2;
    localparam logic [2:0] ST_BAD_HDR = 3'd3;
    localparam logic [2:0] ST_NOT_DIV = 3'd4;

    // classified command kinds
    localparam logic [2:0] K_ALLOC  = 3'd0;
    localparam logic [2:0] K_FREE   = 3'd1;
    localparam logic [2:0] K_BUILD  = 3'd2;
    localparam logic [2:0] K_BAD    = 3'd3;
    localparam logic [2:0] K_BADIDX = 3'd4;

    // register indexes
    localparam logic [2:0] REG_SMALL_BASE  = 3'd0;
    localparam logic [2:0] REG_SMALL_SIZE  = 3'd1;
    localparam logic [2:0] REG_SMALL_COUNT = 3'd2;
    localparam logic [2:0] REG_LARGE_BASE  = 3'd3;
    localparam logic [2:0] REG_LARGE_SIZE  = 3'd4;
    localparam logic [2:0] REG_LARGE_COUNT = 3'd5;
    localparam logic [2:0] REG_HDR_BYTES   = 3'd6;

    localparam int SLICE_W = 11;   // stored slice number, counts reach 2047
    localparam int QDEPTH  = 2;

    typedef struct packed {
        logic [2:0] kind;
        logic       pool;
        logic [9:0] slice;
    } t_cmd;

    typedef struct packed {
        logic [47:0] small_base;
        logic [15:0] small_size;
        logic [10:0] small_count;
        logic [47:0] large_base;
        logic [15:0] large_size;
        logic [10:0] large_count;
        logic [7:0]  hdr_bytes;
    } t_cfg;

endpackage
`default_nettype wire

FILE: sv/sbpa_front.sv
// Front end: classifies incoming items and queues them for the back end.
`default_nettype none
module sbpa_front #(
    parameter int MAX_SLICES = 1024
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_ready,
    input  wire  [1:0]        i_op,
    input  wire  [1:0]        i_pool,
    input  wire  [9:0]        i_slice,
    input  wire               i_hold,
    output sbpa_pkg::t_cmd    o_cmd,
    output logic              o_cmd_valid,
    input  wire               i_pop
);
    import sbpa_pkg::*;

    t_cmd       r_q [QDEPTH];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_cmd       cls;
    logic       push;

    always_comb begin
        cls.pool  = i_pool[0];
        cls.slice = i_slice;
        if (i_pool[1] || (i_op != OP_ALLOC && i_op != OP_FREE && i_op != OP_BUILD)) begin
            cls.kind = K_BAD;
        end else if (i_op == OP_ALLOC) begin
            cls.kind = K_ALLOC;
        end else if (i_op == OP_FREE) begin
            cls.kind = ({22'd0, i_slice} >= 32'(MAX_SLICES)) ? K_BADIDX : K_FREE;
        end else begin
            cls.kind = K_BUILD;
        end
    end

    assign o_ready     = (r_cnt != 2'(QDEPTH)) && !i_hold;
    assign push        = i_valid && o_ready;
    assign o_cmd       = r_q[r_rp];
    assign o_cmd_valid = (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cls;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end

endmodule
`default_nettype wire

FILE: sv/sbpa_back.sv
// Back end: free stacks, slice headers and the command sequencer.
`default_nettype none
module sbpa_back #(
    parameter int SUBPOOLS   = 4,
    parameter int MAX_SLICES = 1024
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  sbpa_pkg::t_cmd    i_cmd,
    input  wire               i_cmd_valid,
    output logic              o_pop,
    input  sbpa_pkg::t_cfg    i_cfg,
    output logic              o_busy,
    output logic              o_valid,
    input  wire               i_ready,
    output logic [2:0]        o_status,
    output logic [9:0]        o_slice,
    output logic [47:0]       o_addr
);
    import sbpa_pkg::*;

    localparam int CAP   = MAX_SLICES / SUBPOOLS;
    localparam int MA    = $clog2(2 * MAX_SLICES);
    localparam int DW    = $clog2(CAP + 1);
    localparam int RW    = (SUBPOOLS > 1) ? $clog2(SUBPOOLS) : 1;
    localparam int DIW   = $clog2(2 * SUBPOOLS);
    localparam int JW    = $clog2(MAX_SLICES);
    localparam int HW    = RW + 1;
    localparam int DSH   = 16;
    localparam int RECIP = ((1 << DSH) + SUBPOOLS - 1) / SUBPOOLS;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_ARD   = 4'd2;
    localparam logic [3:0] S_AADD  = 4'd3;
    localparam logic [3:0] S_FHDR  = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_SWEEP = 4'd6;

    logic [SLICE_W-1:0] stk_mem [2 * MAX_SLICES];
    logic [HW-1:0]      hdr_mem [2 * MAX_SLICES];

    logic [3:0]         r_state;
    logic [RW-1:0]      r_rr [2];
    logic [DW-1:0]      r_depth [2 * SUBPOOLS];
    logic               r_pool;
    logic [9:0]         r_slice;
    logic [10:0]        r_count;
    logic [10:0]        r_n;
    logic [JW-1:0]      r_j;
    logic [DW-1:0]      r_k;
    logic [RW-1:0]      r_s;
    logic [JW-1:0]      r_saddr;
    logic [JW-1:0]      r_sbase;
    logic [MA-1:0]      r_clr;
    logic [26:0]        r_prod;
    logic [SLICE_W-1:0] r_stk_rd;
    logic [HW-1:0]      r_hdr_rd;
    logic               r_out_valid;
    logic [2:0]         r_status;
    logic [9:0]         r_oslice;
    logic [47:0]        r_oaddr;

    logic               cmd_pool;
    logic [10:0]        cmd_count;
    logic [RW-1:0]      a_sub;
    logic [DIW-1:0]     a_di;
    logic [DW-1:0]      a_depth;
    logic [RW-1:0]      f_sub;
    logic [DIW-1:0]     f_di;
    logic [DW-1:0]      f_depth;
    logic               f_ok;
    logic               in_range;
    logic [47:0]        sel_base;
    logic [15:0]        sel_size;
    logic [27:0]        div_prod;
    logic [10:0]        div_n;
    logic [10:0]        div_back;
    logic               res_done;
    logic               stk_we;
    logic [MA-1:0]      stk_wa;
    logic [SLICE_W-1:0] stk_wd;
    logic [MA-1:0]      stk_ra;
    logic               hdr_we;
    logic [MA-1:0]      hdr_wa;
    logic [HW-1:0]      hdr_wd;
    logic [MA-1:0]      hdr_ra;

    assign o_pop    = (r_state == S_IDLE) && i_cmd_valid && (!r_out_valid || i_ready);
    assign o_busy   = (r_state == S_CLEAR);
    assign o_valid  = r_out_valid;
    assign o_status = r_status;
    assign o_slice  = r_oslice;
    assign o_addr   = r_oaddr;

    always_comb begin
        cmd_pool  = i_cmd.pool;
        cmd_count = cmd_pool ? i_cfg.large_count : i_cfg.small_count;
        a_sub     = r_rr[cmd_pool];
        a_di      = DIW'(int'(cmd_pool) * SUBPOOLS + int'(a_sub));
        a_depth   = r_depth[a_di];
        f_sub     = r_hdr_rd[RW-1:0];
        f_di      = DIW'(int'(r_pool) * SUBPOOLS + int'(f_sub));
        f_depth   = r_depth[f_di];
        f_ok      = r_hdr_rd[HW-1] && (int'(f_depth) < CAP);
        in_range  = int'(r_j) < int'(r_count);
        sel_base  = r_pool ? i_cfg.large_base : i_cfg.small_base;
        sel_size  = r_pool ? i_cfg.large_size : i_cfg.small_size;
        // count over SUBPOOLS by reciprocal multiply, exact for counts up to 2047
        div_prod  = 28'(r_count) * 28'(RECIP);
        div_n     = div_prod[DSH+10:DSH];
        div_back  = 11'(int'(div_n) * SUBPOOLS);
        stk_ra    = MA'(int'(cmd_pool) * MAX_SLICES + int'(a_sub) * CAP + int'(a_depth) - 1);
        hdr_ra    = MA'(int'(cmd_pool) * MAX_SLICES + int'(i_cmd.slice));
        stk_we    = 1'b0;
        stk_wa    = '0;
        stk_wd    = '0;
        hdr_we    = 1'b0;
        hdr_wa    = '0;
        hdr_wd    = '0;
        unique case (r_state)
            S_CLEAR: begin
                hdr_we = 1'b1;
                hdr_wa = r_clr;
            end
            S_FHDR: begin
                stk_we = f_ok;
                stk_wa = MA'(int'(r_pool) * MAX_SLICES + int'(f_sub) * CAP + int'(f_depth));
                stk_wd = SLICE_W'(r_slice);
            end
            S_SWEEP: begin
                hdr_we = 1'b1;
                hdr_wa = MA'(int'(r_pool) * MAX_SLICES + int'(r_j));
                hdr_wd = in_range ? {1'b1, r_s} : '0;
                stk_we = in_range;
                stk_wa = MA'(int'(r_pool) * MAX_SLICES + int'(r_saddr));
                stk_wd = SLICE_W'(r_j);
            end
            default: ;
        endcase
    end

    // raise a result at the edge where the current command finishes
    always_comb begin
        res_done = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    unique case (i_cmd.kind)
                        K_ALLOC: res_done = (a_depth == '0);
                        K_FREE:  res_done = 1'b0;
                        K_BUILD: res_done = (int'(cmd_count) > MAX_SLICES);
                        default: res_done = 1'b1;
                    endcase
                end
            end
            S_AADD:  res_done = 1'b1;
            S_FHDR:  res_done = 1'b1;
            S_DIV:   res_done = (div_back != r_count);
            S_SWEEP: res_done = (int'(r_j) == MAX_SLICES - 1);
            default: res_done = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            stk_mem[stk_wa] <= stk_wd;
        end
        r_stk_rd <= stk_mem[stk_ra];
    end

    always_ff @(posedge i_clk) begin
        if (hdr_we) begin
            hdr_mem[hdr_wa] <= hdr_wd;
        end
        r_hdr_rd <= hdr_mem[hdr_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_rr[0]     <= '0;
            r_rr[1]     <= '0;
            for (int i = 0; i < 2 * SUBPOOLS; i++) begin
                r_depth[i] <= '0;
            end
        end else begin
            r_out_valid <= (r_out_valid && !i_ready) || res_done;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + MA'(1);
                    if (int'(r_clr) == 2 * MAX_SLICES - 1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (o_pop) begin
                        r_pool   <= cmd_pool;
                        r_slice  <= i_cmd.slice;
                        r_oslice <= '0;
                        r_oaddr  <= '0;
                        unique case (i_cmd.kind)
                            K_ALLOC: begin
                                r_rr[cmd_pool] <= (int'(a_sub) == SUBPOOLS - 1) ?
                                                  '0 : a_sub + RW'(1);
                                if (a_depth == '0) begin
                                    r_status <= ST_EMPTY;
                                end else begin
                                    r_depth[a_di] <= a_depth - DW'(1);
                                    r_state       <= S_ARD;
                                end
                            end
                            K_FREE: begin
                                r_state <= S_FHDR;
                            end
                            K_BUILD: begin
                                r_count <= cmd_count;
                                r_n     <= '0;
                                if (int'(cmd_count) > MAX_SLICES) begin
                                    r_status <= ST_NOT_DIV;
                                end else begin
                                    r_state <= S_DIV;
                                end
                            end
                            K_BADIDX: begin
                                r_status <= ST_BAD_HDR;
                            end
                            default: begin
                                r_status <= ST_INVALID;
                            end
                        endcase
                    end
                end
                S_ARD: begin
                    r_oslice <= r_stk_rd[9:0];
                    r_prod   <= 27'(r_stk_rd) * 27'(sel_size);
                    r_state  <= S_AADD;
                end
                S_AADD: begin
                    r_oaddr  <= sel_base + 48'(r_prod) + 48'(i_cfg.hdr_bytes);
                    r_status <= ST_OK;
                    r_state  <= S_IDLE;
                end
                S_FHDR: begin
                    if (f_ok) begin
                        r_depth[f_di] <= f_depth + DW'(1);
                        r_status      <= ST_OK;
                    end else begin
                        r_status <= ST_BAD_HDR;
                    end
                    r_state <= S_IDLE;
                end
                S_DIV: begin
                    r_n <= div_n;
                    if (div_back != r_count) begin
                        r_status <= ST_NOT_DIV;
                        r_state  <= S_IDLE;
                    end else begin
                        r_j     <= '0;
                        r_k     <= '0;
                        r_s     <= '0;
                        r_saddr <= '0;
                        r_sbase <= '0;
                        r_state <= S_SWEEP;
                    end
                end
                S_SWEEP: begin
                    if (in_range) begin
                        if (int'(r_k) + 1 == int'(r_n)) begin
                            r_k     <= '0;
                            r_s     <= r_s + RW'(1);
                            r_saddr <= JW'(int'(r_sbase) + CAP);
                            r_sbase <= JW'(int'(r_sbase) + CAP);
                        end else begin
                            r_k     <= r_k + DW'(1);
                            r_saddr <= r_saddr + JW'(1);
                        end
                    end
                    r_j <= r_j + JW'(1);
                    if (int'(r_j) == MAX_SLICES - 1) begin
                        for (int i = 0; i < SUBPOOLS; i++) begin
                            r_depth[int'(r_pool) * SUBPOOLS + i] <= DW'(r_n);
                        end
                        r_status <= ST_OK;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !r_out_valid)
        else $error("result raised during header clearing pass");
    a_empty_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_cmd.kind == K_ALLOC && a_depth == '0) |=>
        (r_out_valid && r_status == ST_EMPTY && r_state == S_IDLE))
        else $error("alloc on empty subpool did not report empty");
    a_alloc_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_AADD) |=> (r_out_valid && r_status == ST_OK))
        else $error("alloc address stage did not deliver a result");
`endif

endmodule
`default_nettype wire

FILE: sv/sharded_buffer_pool_allocator.sv
// Top level of the sharded buffer pool allocator: register file and stream ports.
//
//  channel | direction | handshake          | payload
//  s       | in        | i_s_tvalid/o_s_tready | tuser op,pool; tdata slice_index
//  m       | out       | o_m_tvalid/i_m_tready | tuser status; tdata slice,address
//  apb     | in        | psel/penable, pready=1 | 64-bit registers at 8*index
//
//  Alloc runs as depth update, then stack read plus multiply, then address add.
//  Free runs as header read, then stack write; errors found up front are reported from idle.
//  Build runs a divide step, then a sweep over all MAX_SLICES headers of the pool.
//  After reset all 2*MAX_SLICES header entries are cleared; no item is taken.
//  A two-item queue keeps accepting, until full, while a result waits on the m side.
`default_nettype none
module sharded_buffer_pool_allocator #(
    parameter int SUBPOOLS   = 4,
    parameter int MAX_SLICES = 1024
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [15:0] i_s_tdata,   // [9:0] slice_index, rest zero
    input  wire  [3:0]  i_s_tuser,   // [1:0] operation, [3:2] pool_select
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [63:0] o_m_tdata,   // [9:0] granted_slice, [57:10] buffer_address
    output logic [2:0]  o_m_tuser,   // [2:0] status
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [5:0]  paddr,
    input  wire  [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import sbpa_pkg::*;

    t_cfg        r_cfg;
    t_cmd        cmd;
    logic        cmd_valid;
    logic        pop;
    logic        busy;
    logic [9:0]  out_slice;
    logic [47:0] out_addr;
    logic [2:0]  reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.small_base  <= '0;
            r_cfg.small_size  <= 16'd256;
            r_cfg.small_count <= '0;
            r_cfg.large_base  <= '0;
            r_cfg.large_size  <= 16'd2048;
            r_cfg.large_count <= '0;
            r_cfg.hdr_bytes   <= 8'd16;
        end else if (psel && penable && pwrite && pready) begin
            unique case (reg_idx)
                REG_SMALL_BASE:  r_cfg.small_base  <= pwdata[47:0];
                REG_SMALL_SIZE:  r_cfg.small_size  <= pwdata[15:0];
                REG_SMALL_COUNT: r_cfg.small_count <= pwdata[10:0];
                REG_LARGE_BASE:  r_cfg.large_base  <= pwdata[47:0];
                REG_LARGE_SIZE:  r_cfg.large_size  <= pwdata[15:0];
                REG_LARGE_COUNT: r_cfg.large_count <= pwdata[10:0];
                REG_HDR_BYTES:   r_cfg.hdr_bytes   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SMALL_BASE:  prdata = {16'd0, r_cfg.small_base};
            REG_SMALL_SIZE:  prdata = {48'd0, r_cfg.small_size};
            REG_SMALL_COUNT: prdata = {53'd0, r_cfg.small_count};
            REG_LARGE_BASE:  prdata = {16'd0, r_cfg.large_base};
            REG_LARGE_SIZE:  prdata = {48'd0, r_cfg.large_size};
            REG_LARGE_COUNT: prdata = {53'd0, r_cfg.large_count};
            REG_HDR_BYTES:   prdata = {56'd0, r_cfg.hdr_bytes};
            default:         prdata = '0;
        endcase
    end

    sbpa_front #(
        .MAX_SLICES (MAX_SLICES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_op        (i_s_tuser[1:0]),
        .i_pool      (i_s_tuser[3:2]),
        .i_slice     (i_s_tdata[9:0]),
        .i_hold      (busy),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_pop       (pop)
    );

    sbpa_back #(
        .SUBPOOLS   (SUBPOOLS),
        .MAX_SLICES (MAX_SLICES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_pop       (pop),
        .i_cfg       (r_cfg),
        .o_busy      (busy),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_status    (o_m_tuser),
        .o_slice     (out_slice),
        .o_addr      (out_addr)
    );

    assign o_m_tdata = {6'd0, out_addr, out_slice};

endmodule
`default_nettype wire
